### sv/rbr_pkg.sv
// shared types and constants for the rollback bit reader
package rbr_pkg;

  localparam int BUF_BYTES_DEF = 64;
  localparam int MAX_READ      = 64;
  localparam int ACC_BYTES     = 9;

  typedef enum logic [1:0] {
    REQ_PUSH     = 2'd0,
    REQ_READ     = 2'd1,
    REQ_ALIGN    = 2'd2,
    REQ_ROLLBACK = 2'd3
  } req_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FIN,
    ST_OUT
  } rbr_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_in;
    logic [6:0] read_width;
    logic       sign_extend;
    logic [9:0] rollback_amount;
  } rbr_req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [9:0]  bits_done;
    logic        push_accepted;
    logic [31:0] total_bits;
  } rbr_res_t;

endpackage

### sv/rbr_ring.sv
// byte ring memory, one write and one registered read port
module rbr_ring #(
  parameter int BUF_BYTES = rbr_pkg::BUF_BYTES_DEF,
  parameter int AW        = $clog2(rbr_pkg::BUF_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/rbr_ctrl.sv
// request sequencer: ring pointers, byte fetch loop and result assembly
module rbr_ctrl #(
  parameter int BUF_BYTES = rbr_pkg::BUF_BYTES_DEF,
  parameter int AW        = $clog2(rbr_pkg::BUF_BYTES_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rbr_pkg::rbr_req_t req,
  output logic              res_valid,
  input  logic              res_take,
  output rbr_pkg::rbr_res_t res,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output logic [7:0]        mem_wr_data,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_addr,
  input  logic [7:0]        mem_rd_data
);

  import rbr_pkg::*;

  localparam int RB = BUF_BYTES * 8;
  localparam int PW = $clog2(RB);
  localparam int UW = $clog2(RB + 1);
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int SW = ((UW > 10) ? UW : 10) + 1;
  localparam int ABITS = ACC_BYTES * 8;

  rbr_state_t state_r, state_nxt;
  rbr_req_t   req_r, req_nxt;

  logic [PW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [UW-1:0] unread_r, unread_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [CW-1:0] wcnt_r, wcnt_nxt;

  logic [6:0]    got_r, got_nxt;
  logic [2:0]    shift_r, shift_nxt;
  logic [3:0]    nbytes_r, nbytes_nxt;
  logic [3:0]    iss_cnt_r, iss_cnt_nxt;
  logic [3:0]    col_cnt_r, col_cnt_nxt;
  logic [AW-1:0] raddr_r, raddr_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_ok_r, pend_ok_nxt;
  logic          sext_r, sext_nxt;
  logic [ABITS-1:0] acc_r, acc_nxt;

  logic [63:0] res_value_r, res_value_nxt;
  logic [9:0]  res_done_r, res_done_nxt;
  logic        res_acc_r, res_acc_nxt;

  // request arithmetic
  logic [6:0]    want;
  logic [UW-1:0] got_u;
  logic [6:0]    got;
  logic [7:0]    span;
  logic [2:0]    skip3;
  logic [UW-1:0] skip_u;
  logic [6:0]    adv;
  logic [PW:0]   rp_sum;
  logic [PW:0]   rp_fwd;
  logic [SW-1:0] amt;
  logic [SW-1:0] room;
  logic [SW-1:0] amt_c;
  logic [SW-1:0] rp_back;
  logic          push_ok;
  logic [AW-1:0] fill_inc;
  logic [AW-1:0] raddr_inc;

  // final formatting of a read
  logic [ABITS-1:0] acc_sh;
  logic [63:0]      rmask;
  logic [63:0]      rval;
  logic [5:0]       sbit;

  always_comb begin
    want   = (req_r.read_width > 7'(MAX_READ)) ? 7'(MAX_READ) : req_r.read_width;
    got_u  = (UW'(want) < unread_r) ? UW'(want) : unread_r;
    got    = got_u[6:0];
    span   = {5'd0, rp_r[2:0]} + {1'b0, got} + 8'd7;
    skip3  = 3'd0 - rp_r[2:0];
    skip_u = (UW'(skip3) > unread_r) ? unread_r : UW'(skip3);
    adv    = (req_r.req_type == REQ_READ) ? got : {4'd0, skip_u[2:0]};
    rp_sum = (PW+1)'(rp_r) + (PW+1)'(adv);
    rp_fwd = (rp_sum >= (PW+1)'(RB)) ? (rp_sum - (PW+1)'(RB)) : rp_sum;
    amt    = SW'(req_r.rollback_amount);
    room   = SW'(RB) - SW'(unread_r);
    amt_c  = (amt > room) ? room : amt;
    rp_back = (amt_c > SW'(rp_r)) ? (SW'(rp_r) + SW'(RB) - amt_c) : (SW'(rp_r) - amt_c);
    push_ok = ((UW+1)'(unread_r) + (UW+1)'(8)) <= (UW+1)'(RB);
    fill_inc  = (fill_r == AW'(BUF_BYTES - 1)) ? '0 : (fill_r + 1'b1);
    raddr_inc = (raddr_r == AW'(BUF_BYTES - 1)) ? '0 : (raddr_r + 1'b1);

    acc_sh = acc_r >> shift_r;
    rmask  = got_r[6] ? '1 : ((64'd1 << got_r[5:0]) - 64'd1);
    sbit   = got_r[5:0] - 6'd1;
    rval   = acc_sh[63:0] & rmask;
    if (sext_r && (got_r != 7'd0) && !got_r[6] && rval[sbit]) begin
      rval = rval | ~rmask;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if ((req_r.req_type == REQ_READ) && (got != 7'd0)) state_nxt = ST_READ;
        else state_nxt = ST_OUT;
      end
      ST_READ: begin
        if (pend_r && (col_cnt_r == (nbytes_r - 4'd1))) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt       = req_r;
    rp_nxt        = rp_r;
    fill_nxt      = fill_r;
    unread_nxt    = unread_r;
    total_nxt     = total_r;
    wcnt_nxt      = wcnt_r;
    got_nxt       = got_r;
    shift_nxt     = shift_r;
    nbytes_nxt    = nbytes_r;
    iss_cnt_nxt   = iss_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    raddr_nxt     = raddr_r;
    sext_nxt      = sext_r;
    acc_nxt       = acc_r;
    res_value_nxt = res_value_r;
    res_done_nxt  = res_done_r;
    res_acc_nxt   = res_acc_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = fill_r;
    mem_wr_data   = req_r.byte_in;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = raddr_r;
    in_stall      = (state_r != ST_IDLE);
    res_valid     = (state_r == ST_OUT);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) req_nxt = req;
      end
      ST_EXEC: begin
        res_value_nxt = '0;
        res_done_nxt  = '0;
        res_acc_nxt   = 1'b0;
        case (req_code_t'(req_r.req_type))
          REQ_PUSH: begin
            if (push_ok) begin
              mem_wr_en   = 1'b1;
              fill_nxt    = fill_inc;
              unread_nxt  = unread_r + UW'(8);
              wcnt_nxt    = (wcnt_r == CW'(BUF_BYTES)) ? wcnt_r : (wcnt_r + 1'b1);
              res_acc_nxt = 1'b1;
            end
          end
          REQ_READ: begin
            rp_nxt       = rp_fwd[PW-1:0];
            unread_nxt   = unread_r - UW'(got);
            total_nxt    = total_r + 32'(got);
            res_done_nxt = 10'(got);
            got_nxt      = got;
            shift_nxt    = rp_r[2:0];
            nbytes_nxt   = span[6:3];
            sext_nxt     = req_r.sign_extend;
            raddr_nxt    = rp_r[PW-1:3];
            iss_cnt_nxt  = '0;
            col_cnt_nxt  = '0;
          end
          REQ_ALIGN: begin
            rp_nxt       = rp_fwd[PW-1:0];
            unread_nxt   = unread_r - skip_u;
            total_nxt    = total_r + 32'(skip_u[2:0]);
            res_done_nxt = 10'(skip_u[2:0]);
          end
          REQ_ROLLBACK: begin
            rp_nxt       = rp_back[PW-1:0];
            unread_nxt   = unread_r + amt_c[UW-1:0];
            total_nxt    = total_r - 32'(amt_c);
            res_done_nxt = amt_c[9:0];
          end
          default: begin
            res_acc_nxt = 1'b0;
          end
        endcase
      end
      ST_READ: begin
        if (iss_cnt_r < nbytes_r) begin
          mem_rd_en   = 1'b1;
          iss_cnt_nxt = iss_cnt_r + 4'd1;
          raddr_nxt   = raddr_inc;
        end
        if (pend_r) begin
          // bytes never written since reset read as zero
          acc_nxt[col_cnt_r*8 +: 8] = pend_ok_r ? mem_rd_data : 8'd0;
          col_cnt_nxt = col_cnt_r + 4'd1;
        end
      end
      ST_FIN: begin
        res_value_nxt = rval;
      end
      ST_OUT: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    pend_nxt    = mem_rd_en;
    pend_ok_nxt = (CW'(raddr_r) < wcnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rp_r     <= '0;
      fill_r   <= '0;
      unread_r <= '0;
      total_r  <= '0;
      wcnt_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rp_r     <= rp_nxt;
      fill_r   <= fill_nxt;
      unread_r <= unread_nxt;
      total_r  <= total_nxt;
      wcnt_r   <= wcnt_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    got_r       <= got_nxt;
    shift_r     <= shift_nxt;
    nbytes_r    <= nbytes_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    col_cnt_r   <= col_cnt_nxt;
    raddr_r     <= raddr_nxt;
    pend_ok_r   <= pend_ok_nxt;
    sext_r      <= sext_nxt;
    acc_r       <= acc_nxt;
    res_value_r <= res_value_nxt;
    res_done_r  <= res_done_nxt;
    res_acc_r   <= res_acc_nxt;
  end

  assign res.read_value    = res_value_r;
  assign res.bits_done     = res_done_r;
  assign res.push_accepted = res_acc_r;
  assign res.total_bits    = total_r;

  a_unread_bound: assert property (@(posedge clk) disable iff (!rst_n)
    unread_r <= UW'(RB))
    else $error("unread count beyond ring size");

  a_fill_align: assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r[2:0] + unread_r[2:0]) == 3'd0)
    else $error("read position and unread count disagree with byte fill");

  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= CW'(BUF_BYTES))
    else $error("written byte count beyond ring size");

  a_collect_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ((col_cnt_r < nbytes_r) && (nbytes_r <= 4'(ACC_BYTES))))
    else $error("fetch loop collected more bytes than the read spans");

  a_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && (req_r.req_type == REQ_PUSH) && !push_ok)
      |=> ((unread_r == $past(unread_r)) && !res_acc_r))
    else $error("refused push changed the ring");

endmodule

### sv/bitstream_reader_with_rollback_top.sv
// top level: LSB-first bit reader over a byte ring with rollback
// sequence: a request is registered in IDLE and executed in EXEC; a read that gets bits also
//   fetches the n = 1..9 ring bytes the bits span in READ and formats them in FIN
// requests: one at a time; the result waits in OUT until the output register takes it,
//   and only then is the next request taken
// reset: rst_n synchronous active low clears pointers, counts and the sequencer;
//   no clearing pass, a written-byte count makes bytes never written read as zero
module bitstream_reader_with_rollback_top #(
  parameter int BUF_BYTES = rbr_pkg::BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_byte_in,
  input  logic [6:0]  in_read_width,
  input  logic        in_sign_extend,
  input  logic [9:0]  in_rollback_amount,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_value,
  output logic [9:0]  out_bits_done,
  output logic        out_push_accepted,
  output logic [31:0] out_total_bits
);

  import rbr_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);

  // request bundled for the sequencer
  rbr_req_t req;
  rbr_res_t res;
  logic     res_valid;
  logic     res_take;

  // ring memory port
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  // output register, parts the sequencer from the result stall
  logic     out_valid_r, out_valid_nxt;
  rbr_res_t out_res_r, out_res_nxt;

  assign req.req_type        = in_req_type;
  assign req.byte_in         = in_byte_in;
  assign req.read_width      = in_read_width;
  assign req.sign_extend     = in_sign_extend;
  assign req.rollback_amount = in_rollback_amount;

  rbr_ring #(
    .BUF_BYTES (BUF_BYTES),
    .AW        (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rbr_ctrl #(
    .BUF_BYTES (BUF_BYTES),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req         (req),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // the register takes a new result when empty or being drained this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_res_r.read_value;
  assign out_bits_done     = out_res_r.bits_done;
  assign out_push_accepted = out_res_r.push_accepted;
  assign out_total_bits    = out_res_r.total_bits;

endmodule

### tb/tb_top.sv
// self-checking testbench for the rollback bit reader: directed table, then random requests
`timescale 1ns / 100ps

module tb_top;
  import rbr_pkg::*;

  localparam int RING_BYTES   = BUF_BYTES_DEF;
  localparam int RING_BITS    = RING_BYTES * 8;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_PHASES     = 4;
  localparam int N_DIRECTED   = 25;

  // idle percentages per phase: none, sender only, receiver only, both
  localparam int IDLE_PCT  [N_PHASES] = '{0, 46, 0, 28};
  localparam int STALL_PCT [N_PHASES] = '{0, 0, 46, 28};

  // clock and reset
  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  // request channel, all driven from time zero
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type        = REQ_PUSH;
  logic [7:0]  in_byte_in         = 8'h00;
  logic [6:0]  in_read_width      = 7'd0;
  logic        in_sign_extend     = 1'b0;
  logic [9:0]  in_rollback_amount = 10'd0;

  // result channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_read_value;
  logic [9:0]  out_bits_done;
  logic        out_push_accepted;
  logic [31:0] out_total_bits;

  bitstream_reader_with_rollback_top #(
    .BUF_BYTES(RING_BYTES)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_byte_in        (in_byte_in),
    .in_read_width     (in_read_width),
    .in_sign_extend    (in_sign_extend),
    .in_rollback_amount(in_rollback_amount),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_bits_done     (out_bits_done),
    .out_push_accepted (out_push_accepted),
    .out_total_bits    (out_total_bits)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the reader state, updated at each accepted request
  logic [7:0]  ring_mem [RING_BYTES];
  int unsigned read_bit;
  int unsigned fill_bit;
  int unsigned pending_bits;
  logic [31:0] bit_count;

  // results still owed by the block, oldest first
  rbr_res_t    awaited_results [$];
  rbr_res_t    head_res;

  // bookkeeping
  int          n_sent;
  int          n_checked;
  int          mismatches;
  int          n_refused;
  int          n_short;
  int          n_extended;
  int          n_clipped;
  int          quiet_cycles;

  // knobs shared between the sender and the receiver
  int          idle_pct;
  int          stall_pct;
  int          hold_asks;
  int          hold_seen;
  int          hold_left;

  // directed rows; typed ones carry their result, the rest go through the predictor
  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  byte_val;
    logic [6:0]  width;
    logic        sext;
    logic [9:0]  back;
    logic        typed;
    logic [63:0] value;
    logic [9:0]  done;
    logic        acc;
    logic [31:0] total;
  } step_t;

  localparam step_t DIRECTED [N_DIRECTED] = '{
    // empty ring: read and align get nothing
    '{REQ_READ,     8'h00, 7'd8,   1'b0, 10'd0,    1'b1, 64'h0, 10'd0,   1'b0, 32'h0},
    '{REQ_ALIGN,    8'h00, 7'd0,   1'b0, 10'd0,    1'b1, 64'h0, 10'd0,   1'b0, 32'h0},
    // three bytes in, byte extremes
    '{REQ_PUSH,     8'hA5, 7'd0,   1'b0, 10'd0,    1'b1, 64'h0, 10'd0,   1'b1, 32'h0},
    '{REQ_PUSH,     8'h00, 7'd0,   1'b0, 10'd0,    1'b1, 64'h0, 10'd0,   1'b1, 32'h0},
    '{REQ_PUSH,     8'hFF, 7'd0,   1'b0, 10'd0,    1'b1, 64'h0, 10'd0,   1'b1, 32'h0},
    // zero width reads nothing
    '{REQ_READ,     8'h00, 7'd0,   1'b1, 10'd0,    1'b1, 64'h0, 10'd0,   1'b0, 32'h0},
    // 3 bits 101, top bit set, extended
    '{REQ_READ,     8'h00, 7'd3,   1'b1, 10'd0,    1'b1, 64'hFFFF_FFFF_FFFF_FFFD,
      10'd3, 1'b0, 32'd3},
    // align skips 5, then already aligned skips none
    '{REQ_ALIGN,    8'h00, 7'd0,   1'b0, 10'd0,    1'b1, 64'h0, 10'd5,   1'b0, 32'd8},
    '{REQ_ALIGN,    8'h00, 7'd0,   1'b0, 10'd0,    1'b1, 64'h0, 10'd0,   1'b0, 32'd8},
    '{REQ_ROLLBACK, 8'h00, 7'd0,   1'b0, 10'd4,    1'b1, 64'h0, 10'd4,   1'b0, 32'd4},
    '{REQ_READ,     8'h00, 7'd12,  1'b1, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    // oversized width on a short buffer
    '{REQ_READ,     8'h00, 7'd127, 1'b1, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    // step back past never-written bytes, total wraps below zero
    '{REQ_ROLLBACK, 8'h00, 7'd0,   1'b0, 10'd64,   1'b1, 64'h0, 10'd64,  1'b0, 32'hFFFF_FFD8},
    // full 64 bit read is never extended
    '{REQ_READ,     8'h00, 7'd64,  1'b1, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    // rollback clipped to the whole ring, ring is then full
    '{REQ_ROLLBACK, 8'h00, 7'd0,   1'b0, 10'd1023, 1'b1, 64'h0, 10'd512, 1'b0, 32'hFFFF_FE18},
    '{REQ_PUSH,     8'h7E, 7'd0,   1'b0, 10'd0,    1'b1, 64'h0, 10'd0,   1'b0, 32'hFFFF_FE18},
    '{REQ_READ,     8'h00, 7'd64,  1'b0, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    '{REQ_READ,     8'h00, 7'd1,   1'b1, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    '{REQ_READ,     8'h00, 7'd63,  1'b1, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    // rollback limited by the unread bits
    '{REQ_ROLLBACK, 8'h00, 7'd0,   1'b0, 10'd600,  1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    '{REQ_PUSH,     8'h81, 7'd0,   1'b0, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    '{REQ_READ,     8'h00, 7'd5,   1'b0, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    '{REQ_ALIGN,    8'h00, 7'd0,   1'b0, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    // one byte of room, then full again
    '{REQ_PUSH,     8'h81, 7'd0,   1'b0, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0},
    '{REQ_PUSH,     8'h42, 7'd0,   1'b0, 10'd0,    1'b0, 64'h0, 10'd0,   1'b0, 32'h0}
  };

  // expected result of one request, advancing the shadow state
  function automatic rbr_res_t next_reader_result(input rbr_req_t rq);
    rbr_res_t    res;
    int unsigned want, got, skip, room, back, p, i;
    res = '0;
    case (req_code_t'(rq.req_type))
      REQ_PUSH: begin
        if (pending_bits + 8 <= RING_BITS) begin
          ring_mem[fill_bit / 8] = rq.byte_in;
          fill_bit = (fill_bit + 8) % RING_BITS;
          pending_bits += 8;
          res.push_accepted = 1'b1;
        end else begin
          n_refused++;
        end
      end
      REQ_READ: begin
        want = (rq.read_width > 7'd64) ? 64 : rq.read_width;
        got  = (want < pending_bits) ? want : pending_bits;
        if (got < want) n_short++;
        for (i = 0; i < got; i++) begin
          p = (read_bit + i) % RING_BITS;
          res.read_value[i] = ring_mem[p / 8][p % 8];
        end
        if (rq.sign_extend && got > 0 && got < 64 && res.read_value[got - 1]) begin
          res.read_value |= ~64'd0 << got;
          n_extended++;
        end
        read_bit = (read_bit + got) % RING_BITS;
        pending_bits -= got;
        bit_count += got;
        res.bits_done = 10'(got);
      end
      REQ_ALIGN: begin
        skip = (8 - read_bit % 8) % 8;
        if (skip > pending_bits) skip = pending_bits;
        read_bit = (read_bit + skip) % RING_BITS;
        pending_bits -= skip;
        bit_count += skip;
        res.bits_done = 10'(skip);
      end
      REQ_ROLLBACK: begin
        back = rq.rollback_amount;
        room = RING_BITS - pending_bits;
        if (back > room) begin
          back = room;
          n_clipped++;
        end
        read_bit = (read_bit + RING_BITS - back) % RING_BITS;
        pending_bits += back;
        bit_count -= back;
        res.bits_done = 10'(back);
      end
    endcase
    res.total_bits = bit_count;
    return res;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
  endfunction

  // offer one request at the falling edge, predict it once the block takes it
  task automatic send_req(input rbr_req_t rq, input bit typed, input rbr_res_t typed_res);
    rbr_res_t pred;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_req_type        = rq.req_type;
    in_byte_in         = rq.byte_in;
    in_read_width      = rq.read_width;
    in_sign_extend     = rq.sign_extend;
    in_rollback_amount = rq.rollback_amount;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = next_reader_result(rq);
    awaited_results.push_back(typed ? typed_res : pred);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send(input rbr_req_t rq);
    send_req(rq, 1'b0, '0);
  endtask

  // random payload in every field, request code forced
  function automatic rbr_req_t typed_noise(input req_code_t code);
    rbr_req_t rq;
    rq.req_type        = code;
    rq.byte_in         = 8'($urandom);
    rq.read_width      = 7'($urandom);
    rq.sign_extend     = 1'($urandom);
    rq.rollback_amount = 10'($urandom);
    return rq;
  endfunction

  // narrow reads look like header fields; wide ones reach the 64 bit and oversize cases
  function automatic rbr_req_t read_req(input bit narrow);
    rbr_req_t    rq;
    int unsigned pick;
    rq   = typed_noise(REQ_READ);
    pick = $urandom_range(0, 19);
    if (narrow)
      rq.read_width = (pick < 18) ? 7'($urandom_range(1, 16)) : 7'($urandom_range(0, 64));
    else if (pick == 0)
      rq.read_width = 7'd0;
    else if (pick < 3)
      rq.read_width = 7'($urandom_range(65, 127));
    else if (pick < 6)
      rq.read_width = 7'd64;
    else
      rq.read_width = 7'($urandom_range(1, 63));
    return rq;
  endfunction

  function automatic rbr_req_t rollback_req();
    rbr_req_t    rq;
    int unsigned pick;
    rq   = typed_noise(REQ_ROLLBACK);
    pick = $urandom_range(0, 9);
    if (pick < 6)
      rq.rollback_amount = 10'($urandom_range(1, 72));
    else if (pick == 8)
      rq.rollback_amount = 10'($urandom_range(512, 1023));
    else if (pick == 9)
      rq.rollback_amount = 10'(RING_BITS - pending_bits);
    return rq;
  endfunction

  // one random stretch of traffic, often a well-formed push-then-parse sequence
  task automatic random_sequence();
    rbr_req_t    rq;
    int unsigned kind, n, k;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // a short message pushed, then parsed
      n = $urandom_range(1, 12);
      repeat (n) send(typed_noise(REQ_PUSH));
      n = $urandom_range(1, n + 2);
      repeat (n) begin
        k = $urandom_range(0, 19);
        if (k < 14)
          rq = read_req(k < 11);
        else if (k < 17)
          rq = typed_noise(REQ_ALIGN);
        else
          rq = rollback_req();
        send(rq);
      end
    end else if (kind < 50) begin
      // fill until pushes bounce off the full ring
      n = (RING_BITS - pending_bits) / 8 + $urandom_range(1, 3);
      repeat (n) send(typed_noise(REQ_PUSH));
    end else if (kind < 65) begin
      // drain with up to ten wide reads while bits remain, then one more read
      k = 0;
      while (pending_bits > 0 && k < 10) begin
        send(read_req(1'b0));
        k++;
      end
      send(read_req(1'b0));
    end else if (kind < 80) begin
      send(read_req(1'($urandom)));
    end else if (kind < 87) begin
      send(typed_noise(REQ_ALIGN));
    end else if (kind < 95) begin
      send(rollback_req());
    end else begin
      send(typed_noise(req_code_t'($urandom_range(0, 3))));
    end
  endtask

  // receiver: random stall, or a long hold-off when the sender asks for one
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker: each accepted result against the oldest outstanding prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with no request outstanding", 64'd0, out_read_value);
      end else begin
        head_res = awaited_results.pop_front();
        if (out_read_value !== head_res.read_value)
          flag_mismatch("read_value", head_res.read_value, out_read_value);
        if (out_bits_done !== head_res.bits_done)
          flag_mismatch("bits_done", 64'(head_res.bits_done), 64'(out_bits_done));
        if (out_push_accepted !== head_res.push_accepted)
          flag_mismatch("push_accepted", 64'(head_res.push_accepted),
                        64'(out_push_accepted));
        if (out_total_bits !== head_res.total_bits)
          flag_mismatch("total_bits", 64'(head_res.total_bits), 64'(out_total_bits));
      end
    end
  end

  // watchdog: too long without any handshake on either channel
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, awaited_results.size());
    $display("tb_top failed");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    rbr_req_t rq;
    rbr_res_t typed_res;
    int       goal;
    int       phase_start;
    bit       held;
    // shadow state matches the block after reset
    foreach (ring_mem[b]) ring_mem[b] = 8'h00;
    read_bit     = 0;
    fill_bit     = 0;
    pending_bits = 0;
    bit_count    = 32'd0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_asks    = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed rows, no idling
    foreach (DIRECTED[k]) begin
      rq.req_type              = DIRECTED[k].req;
      rq.byte_in               = DIRECTED[k].byte_val;
      rq.read_width            = DIRECTED[k].width;
      rq.sign_extend           = DIRECTED[k].sext;
      rq.rollback_amount       = DIRECTED[k].back;
      typed_res.read_value     = DIRECTED[k].value;
      typed_res.bits_done      = DIRECTED[k].done;
      typed_res.push_accepted  = DIRECTED[k].acc;
      typed_res.total_bits     = DIRECTED[k].total;
      send_req(rq, DIRECTED[k].typed, typed_res);
    end

    // random phases with different idling mixes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct    = IDLE_PCT[ph];
      stall_pct   = STALL_PCT[ph];
      phase_start = n_sent;
      goal        = n_sent + RANDOM_ITEMS / N_PHASES;
      held        = 1'b0;
      while (n_sent < goal) begin
        // long receiver hold-off while requests keep coming
        if ((ph == 0 || ph == 3) && !held && n_sent >= phase_start + 100) begin
          hold_asks++;
          held = 1'b1;
        end
        random_sequence();
      end
      // sender pauses until every result is back
      in_valid = 1'b0;
      while (awaited_results.size() != 0) @(negedge clk);
    end

    // let any late result show up
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests and %0d results: %0d refused pushes, %0d short reads,",
             n_sent, n_checked, n_refused, n_short);
    $display("  %0d sign-extended reads, %0d clipped rollbacks, %0d mismatches",
             n_extended, n_clipped, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
